@@ rtl/led_volume_bar_meter_assert.svh @@
// ----------------------------------------------------------------------------
// LED volume bar meter assertion macros
// Shared concurrent assertion forms. Each expects i_clk and i_rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LED_VOLUME_BAR_METER_ASSERT_SVH
`define LED_VOLUME_BAR_METER_ASSERT_SVH

// Condition holds in the same cycle as the trigger
`define LVBM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger
`define LVBM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lvbm_pkg.sv @@
// ----------------------------------------------------------------------------
// LED volume bar meter package
// Types, constants and arithmetic helpers shared by the meter modules.
// ----------------------------------------------------------------------------
package lvbm_pkg;

    // Strip size and field widths
    localparam int LED_COUNT = 10;
    localparam int IDX_W     = 6;
    localparam int LEVEL_W   = 7;
    localparam int TIME_W    = 32;
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(LED_COUNT - 1);
    localparam logic [LEVEL_W-1:0] PERCENT  = LEVEL_W'(100);
    localparam logic [CHAN_W-1:0]  FULL_AMT = 8'hFF;

    // Fill budget widths
    localparam int FILL_MAX  = 255 * LED_COUNT;
    localparam int BUDGET_W  = $clog2(FILL_MAX + 1);
    localparam int PROD_MAX  = 100 * FILL_MAX;
    localparam int DIV_W     = $clog2(PROD_MAX + 1);

    // Reciprocal of 100, exact for inputs below about six million
    localparam int DIV_SHIFT     = 28;
    localparam int RECIP_100_INT = ((1 << DIV_SHIFT) + 99) / 100;
    localparam int RECIP_W       = $clog2(RECIP_100_INT + 1);
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(RECIP_100_INT);

    // Triangle wave constants: period 1000 ms, 255/500 = 51/100
    localparam int MOD_PERIOD  = 1000;
    localparam int HALF_PERIOD = 500;
    localparam int RES_2P16    = 536;   // 2^16 mod 1000
    localparam int RES_2P10    = 24;    // 2^10 mod 1000
    localparam int WAVE_MUL    = 51;
    localparam int FOLD1_W     = 26;
    localparam int FOLD2_W     = 20;
    localparam int FOLD3_W     = 15;
    localparam int FOLD4_W     = 11;
    localparam int PHASE_W     = 10;
    localparam int HALF_W      = 9;

    // Command queue depth
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_COLOR  = 1'b0,
        CFG_HIGH_COLOR = 1'b1
    } t_cfg_reg;

    // Input beat
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               is_muted;
        logic [TIME_W-1:0]  time_ms;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [IDX_W-1:0]  pixel_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last_pixel;
    } t_out;

    // Classified frame command: fill budget, or fixed blend amount when muted
    typedef struct packed {
        logic                muted;
        logic [BUDGET_W-1:0] amount;
    } t_cmd;

    // Floor of x / 100 by reciprocal multiply
    function automatic logic [DIV_W-1:0] div100(input logic [DIV_W-1:0] x);
        logic [DIV_W+RECIP_W-1:0] prod;
        logic [DIV_W+RECIP_W-1:0] shifted;
        prod    = (DIV_W+RECIP_W)'(x) * (DIV_W+RECIP_W)'(RECIP_100);
        shifted = prod >> DIV_SHIFT;
        return shifted[DIV_W-1:0];
    endfunction

    // Floor of x / 255 for x up to 65279, where the quotient fits in 8 bits
    function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
        logic [2*CHAN_W:0] sum;
        sum = (2*CHAN_W+1)'(x) + (2*CHAN_W+1)'(x >> CHAN_W) + (2*CHAN_W+1)'(1);
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

@@ rtl/lvbm_front.sv @@
// ----------------------------------------------------------------------------
// LED volume bar meter front end
// Accepts input beats and turns each into a frame command: the saturated
// fill budget when unmuted, the triangle-wave blend amount when muted.
// ----------------------------------------------------------------------------
module lvbm_front
    import lvbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_push,
    output t_cmd o_cmd,
    input  logic i_full
);

    logic adv;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_muted1, r_muted2, r_muted3, r_muted4;

    logic [LEVEL_W-1:0] lvl_sat;
    logic [DIV_W-1:0]   n_prod,   r_prod;
    logic [FOLD1_W-1:0] n_fold1,  r_fold1;
    logic [FOLD2_W-1:0] fold2;
    logic [FOLD3_W-1:0] n_fold3,  r_fold3;
    logic [BUDGET_W-1:0] n_budget, r_budget2, r_budget3, r_budget4;
    logic [FOLD4_W-1:0] fold4;
    logic [PHASE_W-1:0] phase;
    logic [HALF_W-1:0]  offset;
    logic [HALF_W-1:0]  rise;
    logic [DIV_W-1:0]   n_wave,   r_wave, r_wave4;
    logic [CHAN_W-1:0]  wave_amt;

    // Advance the whole pipe unless the last stage is blocked by the queue
    assign adv     = !r_v4 || !i_full;
    assign o_stall = !adv;
    assign o_push  = r_v4 && !i_full;

    // Stage 1: saturate level, scale to budget numerator, first time fold
    always_comb begin
        lvl_sat = (i_data.level > PERCENT) ? PERCENT : i_data.level;
        n_prod  = DIV_W'(lvl_sat) * DIV_W'(FILL_MAX);
        n_fold1 = FOLD1_W'(i_data.time_ms[31:16]) * FOLD1_W'(RES_2P16)
                + FOLD1_W'(i_data.time_ms[15:0]);
    end

    // Stage 2: divide budget by 100, fold time twice more by 2^10
    always_comb begin
        n_budget = BUDGET_W'(div100(r_prod));
        fold2    = FOLD2_W'(r_fold1[FOLD1_W-1:10]) * FOLD2_W'(RES_2P10)
                 + FOLD2_W'(r_fold1[9:0]);
        n_fold3  = FOLD3_W'(fold2[FOLD2_W-1:10]) * FOLD3_W'(RES_2P10)
                 + FOLD3_W'(fold2[9:0]);
    end

    // Stage 3: finish phase within the period, fold into a triangle, scale
    always_comb begin
        fold4 = FOLD4_W'(r_fold3[FOLD3_W-1:10]) * FOLD4_W'(RES_2P10)
              + FOLD4_W'(r_fold3[9:0]);
        phase = (fold4 >= FOLD4_W'(MOD_PERIOD)) ? PHASE_W'(fold4 - FOLD4_W'(MOD_PERIOD))
                                               : PHASE_W'(fold4);
        offset = (phase >= PHASE_W'(HALF_PERIOD))
               ? HALF_W'(phase - PHASE_W'(HALF_PERIOD))
               : HALF_W'(PHASE_W'(HALF_PERIOD) - phase);
        rise   = HALF_W'(HALF_PERIOD) - offset;
        n_wave = DIV_W'(rise) * DIV_W'(WAVE_MUL);
    end

    // Stage 4: divide wave by 100 and pick the command amount
    always_comb begin
        wave_amt     = CHAN_W'(div100(r_wave4));
        o_cmd.muted  = r_muted4;
        o_cmd.amount = r_muted4 ? BUDGET_W'(wave_amt) : r_budget4;
    end

    // Hold stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_muted1  <= i_data.is_muted;
            r_prod    <= n_prod;
            r_fold1   <= n_fold1;
            r_muted2  <= r_muted1;
            r_budget2 <= n_budget;
            r_fold3   <= n_fold3;
            r_muted3  <= r_muted2;
            r_budget3 <= r_budget2;
            r_wave    <= n_wave;
            r_muted4  <= r_muted3;
            r_budget4 <= r_budget3;
            r_wave4   <= r_wave;
        end
    end

endmodule

@@ rtl/lvbm_queue.sv @@
// ----------------------------------------------------------------------------
// LED volume bar meter command queue
// Short FIFO of frame commands between the front end and the pixel back end.
// ----------------------------------------------------------------------------
`include "led_volume_bar_meter_assert.svh"

module lvbm_queue
    import lvbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd            r_mem [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;

    assign o_full  = (r_count == QC_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and track fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `LVBM_ASSERT_IMP(q_no_overflow, i_push, !o_full, "command queue pushed while full")
    `LVBM_ASSERT_IMP(q_no_underflow, i_pop, o_valid, "command queue popped while empty")

endmodule

@@ rtl/lvbm_back.sv @@
// ----------------------------------------------------------------------------
// LED volume bar meter back end
// Walks each frame across the strip, one LED per cycle unless stalled, deals
// out the fill budget and blends low toward high color per channel.
// ----------------------------------------------------------------------------
`include "led_volume_bar_meter_assert.svh"

module lvbm_back
    import lvbm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    input  logic [COLOR_W-1:0] i_low_color,
    input  logic [COLOR_W-1:0] i_high_color,
    output logic               o_valid,
    input  logic               i_stall,
    output t_out               o_data
);

    logic adv;
    logic active;
    logic fire;
    logic src_muted;
    logic [BUDGET_W-1:0] src_budget;
    logic [IDX_W-1:0]    src_idx;
    logic [CHAN_W-1:0]   amt;
    logic                last;

    // Sequencer
    logic                r_busy;
    logic                r_muted;
    logic [BUDGET_W-1:0] r_budget;
    logic [IDX_W-1:0]    r_idx;

    // Stage A: pixel index and blend amount
    logic              r_a_valid;
    logic [IDX_W-1:0]  r_a_idx;
    logic [CHAN_W-1:0] r_a_amt;
    logic              r_a_last;

    // Stage B: products
    logic              r_b_valid;
    logic [IDX_W-1:0]  r_b_idx;
    logic              r_b_last;
    logic [2:0]        n_b_neg,  r_b_neg;
    logic [2*CHAN_W-1:0] n_b_prod [3];
    logic [2*CHAN_W-1:0] r_b_prod [3];

    // Output register
    logic r_out_valid;
    t_out n_out, r_out;

    logic [CHAN_W-1:0] lo_ch [3];
    logic [CHAN_W-1:0] hi_ch [3];
    logic [CHAN_W-1:0] mag   [3];
    logic [CHAN_W-1:0] quo   [3];
    logic [CHAN_W-1:0] res   [3];

    // Move the whole back pipe when the output slot is free or taken
    assign adv    = !r_out_valid || !i_stall;
    assign active = r_busy || i_cmd_valid;
    assign fire   = adv && active;
    assign o_pop  = adv && !r_busy && i_cmd_valid;

    // Pick the current frame: running one, else the queue head
    always_comb begin
        src_muted  = r_busy ? r_muted  : i_cmd.muted;
        src_budget = r_busy ? r_budget : i_cmd.amount;
        src_idx    = r_busy ? r_idx    : '0;
        if (src_muted || (src_budget < BUDGET_W'(FULL_AMT))) begin
            amt = src_budget[CHAN_W-1:0];
        end else begin
            amt = FULL_AMT;
        end
        last = (src_idx == LAST_IDX);
    end

    // Step through the strip
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (fire) begin
            r_busy <= !last;
            r_idx  <= src_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_muted  <= src_muted;
            r_budget <= src_muted ? src_budget : src_budget - BUDGET_W'(amt);
        end
    end

    // Split colors into channels, red first
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            lo_ch[c] = i_low_color[COLOR_W-1-CHAN_W*c -: CHAN_W];
            hi_ch[c] = i_high_color[COLOR_W-1-CHAN_W*c -: CHAN_W];
        end
    end

    // Stage B: magnitude of the color span times the amount
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_b_neg[c]  = hi_ch[c] < lo_ch[c];
            mag[c]      = n_b_neg[c] ? lo_ch[c] - hi_ch[c] : hi_ch[c] - lo_ch[c];
            n_b_prod[c] = (2*CHAN_W)'(mag[c]) * (2*CHAN_W)'(r_a_amt);
        end
    end

    // Output stage: scale by 1/255 toward zero and offset from low color
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            quo[c] = div255(r_b_prod[c]);
            res[c] = r_b_neg[c] ? lo_ch[c] - quo[c] : lo_ch[c] + quo[c];
        end
        n_out.pixel_index = r_b_idx;
        n_out.red         = res[0];
        n_out.green       = res[1];
        n_out.blue        = res[2];
        n_out.last_pixel  = r_b_last;
    end

    // Hold stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid   <= active;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
        end
    end

    // Advance stage payloads
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_a_idx  <= src_idx;
            r_a_amt  <= amt;
            r_a_last <= last;
        end
        if (adv) begin
            r_b_idx  <= r_a_idx;
            r_b_last <= r_a_last;
            r_b_neg  <= n_b_neg;
            r_b_prod <= n_b_prod;
            r_out    <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `LVBM_ASSERT_IMP(a_last_on_final, r_a_valid && r_a_last, r_a_idx == LAST_IDX, "last mark off the final LED")
    `LVBM_ASSERT_IMP(busy_past_first, r_busy, r_idx != '0, "running frame points at LED zero")
    `LVBM_ASSERT_NXT(frame_steps, fire && r_busy && !last, r_busy && (r_idx == $past(r_idx) + 1'b1), "frame skipped or repeated an LED")

endmodule

@@ rtl/led_volume_bar_meter.sv @@
// ----------------------------------------------------------------------------
// LED volume bar meter
// Level meter for an LED strip: one color beat per LED for each input beat.
// ----------------------------------------------------------------------------
// Each accepted input beat (level, mute flag, time) yields LED_COUNT result
// beats, LED 0 first, with last_pixel set on the final LED. Unmuted, the fill
// level*255*LED_COUNT/100 (level capped at 100) is dealt out 255 per LED;
// muted, every LED gets one blend that follows a 1000 ms triangle wave. The
// back-end sequencer emits one LED per cycle while the output is not stalled,
// and frames stream back to back. Each input beat passes four front-end
// registers, one slot of the command queue and three back-end registers. A
// four-entry command queue lets the front end keep accepting while the strip
// output is stalled. The user must write low_color and high_color only while
// no frame is in flight; the block itself does not enforce this. There is no
// memory and no start-up clearing pass.
// ----------------------------------------------------------------------------
module led_volume_bar_meter
    import lvbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out                 o_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    logic [COLOR_W-1:0] r_low_color;
    logic [COLOR_W-1:0] r_high_color;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // Write colour registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_color  <= '0;
            r_high_color <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_LOW_COLOR:  r_low_color  <= i_cfg_data;
                CFG_HIGH_COLOR: r_high_color <= i_cfg_data;
                default:        r_low_color  <= r_low_color;
            endcase
        end
    end

    lvbm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (q_push),
        .o_cmd   (front_cmd),
        .i_full  (q_full)
    );

    lvbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    lvbm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_pop        (q_pop),
        .i_low_color  (r_low_color),
        .i_high_color (r_high_color),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule
